>>> hw/rtl/csa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csa_pkg;

  localparam int ACC_W = 40;
  localparam int VAL_W = 32;
  localparam int COL_W = 32;
  localparam int ROW_W = 6;
  localparam int CFG_W = 7;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 1;

  localparam int DEF_MAX_OUT_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;

  localparam logic [CFG_W-1:0] OUT_COLS_RESET = 7'd64;
  localparam logic [APB_ADDR_W-1:0] REG_OUT_COLS = 1'b0;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic {
    REQ_ACC  = 1'b0,
    REQ_READ = 1'b1
  } req_t;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/csa_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module csa_mem #(
  parameter int DEPTH = 4096
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic signed [csa_pkg::ACC_W-1:0]           wdata,
  input  wire logic                                       re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic signed [csa_pkg::ACC_W-1:0]                rdata
);
  import csa_pkg::*;

  logic signed [ACC_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/csa_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module csa_decode #(
  parameter int MAX_OUT_COLS = csa_pkg::DEF_MAX_OUT_COLS,
  parameter int MAX_ROWS = csa_pkg::DEF_MAX_ROWS,
  localparam int DEPTH = MAX_OUT_COLS * MAX_ROWS,
  localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1
) (
  input  wire logic signed [csa_pkg::COL_W-1:0] target_col,
  input  wire logic [csa_pkg::ROW_W-1:0]        row,
  input  wire logic [csa_pkg::CFG_W-1:0]        out_cols,
  output logic                                  hit,
  output logic [ADDR_W-1:0]                     addr
);
  import csa_pkg::*;

  localparam int COLI_W = MAX_OUT_COLS > 1 ? $clog2(MAX_OUT_COLS) : 1;

  logic [COL_W-1:0]  col_u;
  logic [COL_W-1:0]  col_m1;
  logic [COLI_W-1:0] col_idx;

  assign col_u = COL_W'($unsigned(target_col));
  assign col_m1 = col_u - COL_W'(1);
  assign col_idx = col_m1[COLI_W-1:0];

  assign hit = (col_u != '0) && (col_u <= COL_W'(out_cols)) &&
               (col_u <= COL_W'(MAX_OUT_COLS)) && (COL_W'(row) < COL_W'(MAX_ROWS));

  assign addr = ADDR_W'(col_idx) * ADDR_W'(MAX_ROWS) + ADDR_W'(row);

endmodule

`default_nettype wire

>>> hw/rtl/csa_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module csa_alu (
  input  wire csa_pkg::req_t                    req,
  input  wire logic                             hit,
  input  wire logic signed [csa_pkg::ACC_W-1:0] cur,
  input  wire logic signed [csa_pkg::VAL_W-1:0] value,
  output logic signed [csa_pkg::ACC_W-1:0]      wdata,
  output logic signed [csa_pkg::ACC_W-1:0]      rsum
);
  import csa_pkg::*;

  logic signed [ACC_W:0]   wide;
  logic signed [ACC_W-1:0] sat;

  assign wide = (ACC_W+1)'(cur) + (ACC_W+1)'(value);

  always_comb begin
    if (wide[ACC_W] != wide[ACC_W-1]) begin
      sat = wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat = wide[ACC_W-1:0];
    end
  end

  always_comb begin
    case (req)
      REQ_ACC: begin
        wdata = sat;
        rsum = '0;
      end
      REQ_READ: begin
        wdata = '0;
        rsum = hit ? cur : '0;
      end
      default: begin
        wdata = '0;
        rsum = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/column_scatter_accumulator.sv
// Channel   Signals                                   Direction
// request   req_valid req_stall req_type target_col   in (stall out)
//           row value
// response  rsp_valid rsp_stall sum in_range          out (stall in)
// config    psel penable pwrite paddr pwdata prdata   APB slave, out_cols at 0
//
// One item is taken per cycle while req_stall is low; a read result is registered from
// the update stage into sum. The memory read is registered when an item is taken, the
// write as it leaves that stage; an item on the same entry as the one before gets the value
// forwarded. After reset a clearing pass over all MAX_OUT_COLS * MAX_ROWS entries (4096
// by default) writes zero to every entry with req_stall high; configuration writes are taken.
// A stalled response holds a read item in the update stage and stalls the request side.
`timescale 1ns / 1ps
`default_nettype none

module column_scatter_accumulator #(
  parameter int MAX_OUT_COLS = csa_pkg::DEF_MAX_OUT_COLS,
  parameter int MAX_ROWS = csa_pkg::DEF_MAX_ROWS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  req_valid,
  output logic                                       req_stall,
  input  wire logic                                  req_type,
  input  wire logic signed [csa_pkg::COL_W-1:0]      target_col,
  input  wire logic [csa_pkg::ROW_W-1:0]             row,
  input  wire logic signed [csa_pkg::VAL_W-1:0]      value,
  output logic                                       rsp_valid,
  input  wire logic                                  rsp_stall,
  output logic signed [csa_pkg::ACC_W-1:0]           sum,
  output logic                                       in_range,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [csa_pkg::APB_ADDR_W-1:0]        paddr,
  input  wire logic [csa_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [csa_pkg::APB_DATA_W-1:0]             prdata,
  output logic                                       pready
);
  import csa_pkg::*;

  localparam int DEPTH = MAX_OUT_COLS * MAX_ROWS;
  localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;

  logic [CFG_W-1:0] out_cols;

  state_t state;
  state_t state_next;
  logic   clearing;
  logic [ADDR_W-1:0] clr_addr;

  logic              dec_hit;
  logic [ADDR_W-1:0] dec_addr;
  logic              accept;

  logic                    s1_valid;
  req_t                    s1_req;
  logic                    s1_hit;
  logic [ADDR_W-1:0]       s1_addr;
  logic signed [VAL_W-1:0] s1_value;
  logic                    s1_go;
  logic                    fwd_hit;
  logic signed [ACC_W-1:0] fwd_data;

  logic signed [ACC_W-1:0] rd_data;
  logic signed [ACC_W-1:0] cur;
  logic signed [ACC_W-1:0] alu_wdata;
  logic signed [ACC_W-1:0] alu_rsum;

  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic signed [ACC_W-1:0] wr_data;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_OUT_COLS) ? APB_DATA_W'(out_cols) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cols <= OUT_COLS_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_OUT_COLS) begin
      out_cols <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    case (state)
      ST_CLEAR: state_next = (clr_addr == ADDR_W'(DEPTH - 1)) ? ST_RUN : ST_CLEAR;
      ST_RUN:   state_next = ST_RUN;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    case (state)
      ST_CLEAR: clearing = 1'b1;
      ST_RUN:   clearing = 1'b0;
      default:  clearing = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  csa_decode #(
    .MAX_OUT_COLS(MAX_OUT_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_decode (
    .target_col(target_col),
    .row(row),
    .out_cols(out_cols),
    .hit(dec_hit),
    .addr(dec_addr)
  );

  assign s1_go = s1_valid && (s1_req == REQ_ACC || !rsp_valid || !rsp_stall);
  assign req_stall = clearing || (s1_valid && !s1_go);
  assign accept = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req <= req_t'(req_type);
      s1_hit <= dec_hit;
      s1_addr <= dec_addr;
      s1_value <= value;
      fwd_hit <= wr_en && (wr_addr == dec_addr);
      fwd_data <= wr_data;
    end
  end

  csa_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk(clk),
    .we(wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re(accept),
    .raddr(dec_addr),
    .rdata(rd_data)
  );

  assign cur = fwd_hit ? fwd_data : rd_data;

  csa_alu u_alu (
    .req(s1_req),
    .hit(s1_hit),
    .cur(cur),
    .value(s1_value),
    .wdata(alu_wdata),
    .rsum(alu_rsum)
  );

  always_comb begin
    if (clearing) begin
      wr_en = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en = s1_go && s1_hit;
      wr_addr = s1_addr;
      wr_data = alu_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_go && s1_req == REQ_READ) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_req == REQ_READ) begin
      sum <= alu_rsum;
      in_range <= s1_hit;
    end
  end

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !in_range |-> sum == '0)
    else $error("out-of-range read returned a nonzero sum");

  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_req == REQ_READ |=> rsp_valid)
    else $error("read item retired without a result");

  a_clear_writes_zero: assert property (@(posedge clk) disable iff (rst)
    clearing |-> wr_en && wr_data == '0 && req_stall)
    else $error("clearing pass wrote a nonzero entry or took an item");

endmodule

`default_nettype wire

>>> tb/sv/accum_checker.sv
`timescale 1ns / 1ps

module accum_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  input  logic                             req_stall,
  input  logic                             req_type,
  input  logic [csa_pkg::COL_W-1:0]        target_col,
  input  logic [csa_pkg::ROW_W-1:0]        row,
  input  logic signed [csa_pkg::VAL_W-1:0] value,
  input  logic                             rsp_valid,
  input  logic                             rsp_stall,
  input  logic signed [csa_pkg::ACC_W-1:0] sum,
  input  logic                             in_range,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [csa_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [csa_pkg::APB_DATA_W-1:0]   pwdata,
  input  logic                             pready,
  output int                               fail_count,
  output int                               pending
);
  import csa_pkg::*;

  localparam int ENTRIES = DEF_MAX_OUT_COLS * DEF_MAX_ROWS;

  logic signed [ACC_W-1:0] acc_mem [0:ENTRIES-1];
  logic [CFG_W-1:0] cols_in_use;
  logic signed [ACC_W-1:0] want_sum [$];
  logic want_in_range [$];
  int errors = 0;

  function automatic int entry_index(logic [COL_W-1:0] col, logic [ROW_W-1:0] r);
    logic [COL_W-1:0] lim;
    lim = COL_W'(cols_in_use);
    if (lim > DEF_MAX_OUT_COLS) begin
      lim = DEF_MAX_OUT_COLS;
    end
    if (col == 0 || col > lim || r >= DEF_MAX_ROWS) begin
      return -1;
    end
    return int'(col - 1) * DEF_MAX_ROWS + int'(r);
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] a,
                                                       logic signed [VAL_W-1:0] v);
    longint s;
    s = longint'(a) + longint'(v);
    if (s > longint'(ACC_MAX)) begin
      s = longint'(ACC_MAX);
    end else if (s < longint'(ACC_MIN)) begin
      s = longint'(ACC_MIN);
    end
    return s[ACC_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    int idx;
    logic signed [ACC_W-1:0] exp_sum;
    logic exp_in;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        acc_mem[i] = '0;
      end
      cols_in_use = OUT_COLS_RESET;
      want_sum.delete();
      want_in_range.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (want_sum.size() == 0) begin
          $error("response with no read waiting: sum %0d, in_range %0d", sum, in_range);
          errors++;
        end else begin
          exp_sum = want_sum.pop_front();
          exp_in = want_in_range.pop_front();
          if (sum !== exp_sum) begin
            $error("sum mismatch: expected %0d, actual %0d", exp_sum, sum);
            errors++;
          end
          if (in_range !== exp_in) begin
            $error("in_range mismatch: expected %0d, actual %0d", exp_in, in_range);
            errors++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        idx = entry_index(target_col, row);
        if (req_type == REQ_READ) begin
          if (idx >= 0) begin
            want_sum.push_back(acc_mem[idx]);
            want_in_range.push_back(1'b1);
            acc_mem[idx] = '0;
          end else begin
            want_sum.push_back('0);
            want_in_range.push_back(1'b0);
          end
        end else if (idx >= 0) begin
          acc_mem[idx] = sat_add(acc_mem[idx], value);
        end
      end
      if (psel && penable && pwrite && pready && paddr == REG_OUT_COLS) begin
        cols_in_use = pwdata[CFG_W-1:0];
      end
    end
    fail_count <= errors;
    pending <= want_sum.size();
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import csa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic req_type = REQ_ACC;
  logic signed [COL_W-1:0] target_col = '0;
  logic [ROW_W-1:0] row = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic signed [ACC_W-1:0] sum;
  logic in_range;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int col_limit = DEF_MAX_OUT_COLS;
  int sent = 0;

  column_scatter_accumulator u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
    .target_col(target_col), .row(row), .value(value),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .sum(sum), .in_range(in_range),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  accum_checker u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
    .target_col(target_col), .row(row), .value(value),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .sum(sum), .in_range(in_range),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  task automatic push_item(input req_t kind, input logic [COL_W-1:0] col,
                           input logic [ROW_W-1:0] r, input logic [VAL_W-1:0] v);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_type <= kind;
    target_col <= col;
    row <= r;
    value <= v;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_cols(input int cols);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_OUT_COLS;
    pwdata <= cols;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    col_limit = (cols > DEF_MAX_OUT_COLS) ? DEF_MAX_OUT_COLS : cols;
  endtask

  function automatic logic [COL_W-1:0] pick_col();
    if (col_limit == 0) begin
      return 1;
    end
    return $urandom_range(1, col_limit);
  endfunction

  function automatic logic [COL_W-1:0] edge_col();
    case ($urandom_range(6))
      0: return 0;
      1: return col_limit;
      2: return col_limit + 1;
      3: return 32'hFFFFFFFF;
      4: return 32'h80000000;
      5: return 32'h7FFFFFFF;
      default: return 1;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(3))
      0: return $urandom_range(0, 131072) - 65536;
      1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic unload_sequence();
    logic [COL_W-1:0] cols [4];
    logic [ROW_W-1:0] rows [4];
    int n;
    int k;
    int pick;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      cols[i] = pick_col();
      rows[i] = ROW_W'($urandom_range(63));
    end
    pick = 0;
    k = $urandom_range(1, 10);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(2) == 0) begin
        pick = $urandom_range(0, n - 1);
      end
      push_item(REQ_ACC, cols[pick], rows[pick], rand_value());
    end
    for (int i = 0; i < n; i++) begin
      push_item(REQ_READ, cols[i], rows[i], $urandom);
    end
  endtask

  task automatic random_sequence();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) begin
      unload_sequence();
    end else if (roll < 80) begin
      push_item(req_t'($urandom_range(1)), $urandom, ROW_W'($urandom_range(63)), $urandom);
    end else begin
      push_item(req_t'($urandom_range(1)), edge_col(), ROW_W'($urandom_range(63)),
                rand_value());
    end
  endtask

  task automatic saturate(input bit upward);
    logic [COL_W-1:0] c;
    logic [ROW_W-1:0] r;
    c = pick_col();
    r = ROW_W'($urandom_range(63));
    push_item(REQ_READ, c, r, '0);
    repeat (260) push_item(REQ_ACC, c, r, upward ? 32'h7FFFFFFF : 32'h80000000);
    push_item(REQ_READ, c, r, '0);
  endtask

  int phase_cols [4];
  int phase_gap [4] = '{0, 72, 0, 38};
  int phase_stall [4] = '{0, 0, 72, 38};
  int phase_items [4] = '{180, 180, 310, 290};

  initial begin
    phase_cols[0] = $urandom_range(2, 63);
    phase_cols[1] = 1;
    phase_cols[2] = 127;
    phase_cols[3] = 64;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_item(REQ_ACC, 1, 0, 32'h7FFFFFFF);
    push_item(REQ_ACC, 1, 0, 32'h7FFFFFFF);
    push_item(REQ_READ, 1, 0, '0);
    push_item(REQ_READ, 1, 0, '0);
    push_item(REQ_ACC, 64, 63, 32'h80000000);
    push_item(REQ_ACC, 64, 63, 1);
    push_item(REQ_READ, 64, 63, '0);
    push_item(REQ_ACC, 0, 5, 100);
    push_item(REQ_ACC, 65, 5, 100);
    push_item(REQ_ACC, 32'hFFFFFFFF, 5, 100);
    push_item(REQ_ACC, 32'h80000000, 5, 100);
    push_item(REQ_ACC, 32'h7FFFFFFF, 5, 100);
    push_item(REQ_READ, 0, 5, '0);
    push_item(REQ_READ, 65, 5, '0);
    push_item(REQ_READ, 32'h80000000, 5, '0);
    push_item(REQ_READ, 32'h7FFFFFFF, 5, '0);
    push_item(REQ_READ, 32'hFFFFFFFF, 5, '0);
    push_item(REQ_ACC, 2, 5, -3);
    push_item(REQ_READ, 2, 5, '0);
    push_item(REQ_READ, 33, 17, '0);
    push_item(REQ_ACC, 64, 0, 32'h12345678);
    push_item(REQ_READ, 64, 0, '0);

    for (int p = 0; p < 4; p++) begin
      drain();
      write_cols(phase_cols[p]);
      gap_pct = phase_gap[p];
      stall_pct = phase_stall[p];
      sent = 0;
      if (p >= 2) begin
        saturate(p == 2);
      end
      while (sent < phase_items[p]) begin
        random_sequence();
      end
    end

    drain();
    write_cols(0);
    repeat (20) random_sequence();

    drain();
    stall_pct = 0;
    repeat (16) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
